/* hw/rtl/fha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fha_pkg
// Shared types, codes and defaults for the descriptor allocator.
// ----------------------------------------------------------------------------
package fha_pkg;

  // default configuration
  localparam int MAX_FILES_DEF = 16;
  localparam int FIRST_FD_DEF  = 3;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int FD_W     = 8;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;

  // highest descriptor number that names a standard stream
  localparam logic [FD_W-1:0] CONSOLE_LAST = 8'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FD    = 2'd1,
    ST_BAD_FD   = 2'd2,
    ST_RESERVED = 2'd3
  } status_t;

endpackage

/* hw/rtl/fha_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fha_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when re is high.
// ----------------------------------------------------------------------------
module fha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/file_handle_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_handle_allocator
// Hands out descriptor numbers FIRST_FD .. FIRST_FD+MAX_FILES-1, each bound
// to a 32-bit handle. Freed numbers go on a LIFO stack and are reused first.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | to block  | in_valid/in_stall  | cmd, fd_number, handle_in
//  out_    | from block| out_valid/out_stall| status, fd_out, handle_out,
//          |           |                    | is_console
//
//  - Each item has an accept step and an execute step: the accept edge issues
//    the registered reads of the handle RAM and the free-stack RAM; execute
//    does the update and loads the output register once that register is free.
//    One item in flight: no new item is accepted until the last leaves execute.
//  - in_stall is high while an item is in flight. An item stays in execute
//    until the output register is empty or drained in that cycle, so a
//    stalled result keeps in_stall high for every cycle of the stall.
//  - Reset (rst_n low, synchronous) clears counters, the on-list bits and the
//    per-entry valid bits of the handle table; no clearing pass is needed.
//  - The free-stack RAM is not reset; only pushed entries are ever used.
// ----------------------------------------------------------------------------
module file_handle_allocator #(
  parameter int MAX_FILES = fha_pkg::MAX_FILES_DEF,
  parameter int FIRST_FD  = fha_pkg::FIRST_FD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fha_pkg::CMD_W-1:0]     in_cmd,
  input  logic [fha_pkg::FD_W-1:0]      in_fd_number,
  input  logic [fha_pkg::HANDLE_W-1:0]  in_handle_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fha_pkg::STATUS_W-1:0]  out_status,
  output logic [fha_pkg::FD_W-1:0]      out_fd_out,
  output logic [fha_pkg::HANDLE_W-1:0]  out_handle_out,
  output logic                          out_is_console
);

  // slot index and counter widths
  localparam int SW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int CW = $clog2(MAX_FILES + 1);
  localparam logic [fha_pkg::FD_W-1:0] FIRST_FD_V  = fha_pkg::FD_W'(FIRST_FD);
  localparam logic [fha_pkg::FD_W:0]   MAX_FILES_W = (fha_pkg::FD_W + 1)'(MAX_FILES);
  localparam logic [CW-1:0]            MAX_CNT     = CW'(MAX_FILES);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                          state_r, state_nxt;
  fha_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [fha_pkg::FD_W-1:0]        fd_r, fd_nxt;
  logic [fha_pkg::HANDLE_W-1:0]    handle_r, handle_nxt;
  logic [SW-1:0]                   slot_r, slot_nxt;      // slot named by fd_number
  logic                            in_range_r, in_range_nxt;
  logic [CW-1:0]                   free_count_r, free_count_nxt;
  logic [CW-1:0]                   fresh_next_r, fresh_next_nxt;
  logic [MAX_FILES-1:0]            on_free_r, on_free_nxt;   // number is on the stack
  logic [MAX_FILES-1:0]            hvalid_r, hvalid_nxt;     // table entry written since reset/free
  logic                            out_valid_r, out_valid_nxt;
  fha_pkg::status_t                out_status_r, out_status_nxt;
  logic [fha_pkg::FD_W-1:0]        out_fd_r, out_fd_nxt;
  logic [fha_pkg::HANDLE_W-1:0]    out_handle_r, out_handle_nxt;
  logic                            out_console_r, out_console_nxt;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic                            tbl_we;
  logic [SW-1:0]                   tbl_waddr;
  logic [fha_pkg::HANDLE_W-1:0]    tbl_rdata;
  logic                            stk_we;
  logic [SW-1:0]                   stk_waddr;
  logic [SW-1:0]                   stk_raddr;
  logic [SW-1:0]                   stk_rdata;

  // --------------------------------------------------------------------------
  // Front end: decode the incoming descriptor number
  // --------------------------------------------------------------------------
  logic                            accept;
  logic                            out_free;
  logic                            exec_fire;
  logic [fha_pkg::FD_W-1:0]        in_diff;
  logic                            in_range;
  logic [SW-1:0]                   in_slot;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign exec_fire = (state_r == S_EXEC) && out_free;

  assign in_diff  = in_fd_number - FIRST_FD_V;
  assign in_range = (in_fd_number >= FIRST_FD_V) && ({1'b0, in_diff} < MAX_FILES_W);
  assign in_slot  = in_diff[SW-1:0];

  // top of stack; only consumed when free_count is nonzero
  assign stk_raddr = SW'(free_count_r - CW'(1));

  fha_ram #(
    .WIDTH (fha_pkg::HANDLE_W),
    .DEPTH (MAX_FILES),
    .AW    (SW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (handle_r),
    .re    (accept),
    .raddr (in_slot),
    .rdata (tbl_rdata)
  );

  fha_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_FILES),
    .AW    (SW)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (slot_r),
    .re    (accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // --------------------------------------------------------------------------
  // Execute: read data is valid in S_EXEC; nothing writes the RAMs between
  // the read and here, so no forwarding is required.
  // --------------------------------------------------------------------------
  logic                            pop_ok;
  logic                            fresh_ok;
  logic [SW-1:0]                   alloc_slot;

  assign pop_ok     = (free_count_r != '0);
  assign fresh_ok   = (fresh_next_r < MAX_CNT);
  assign alloc_slot = pop_ok ? stk_rdata : fresh_next_r[SW-1:0];

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    fd_nxt          = fd_r;
    handle_nxt      = handle_r;
    slot_nxt        = slot_r;
    in_range_nxt    = in_range_r;
    free_count_nxt  = free_count_r;
    fresh_next_nxt  = fresh_next_r;
    on_free_nxt     = on_free_r;
    hvalid_nxt      = hvalid_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_fd_nxt      = out_fd_r;
    out_handle_nxt  = out_handle_r;
    out_console_nxt = out_console_r;
    tbl_we          = 1'b0;
    tbl_waddr       = alloc_slot;
    stk_we          = 1'b0;
    stk_waddr       = free_count_r[SW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = fha_pkg::cmd_t'(in_cmd);
          fd_nxt       = in_fd_number;
          handle_nxt   = in_handle_in;
          slot_nxt     = in_slot;
          in_range_nxt = in_range;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = fha_pkg::ST_OK;
          out_fd_nxt      = '0;
          out_handle_nxt  = '0;
          out_console_nxt = 1'b0;
          unique case (cmd_r)
            fha_pkg::CMD_ALLOC: begin
              if (pop_ok || fresh_ok) begin
                if (pop_ok) begin
                  free_count_nxt         = free_count_r - CW'(1);
                  on_free_nxt[alloc_slot] = 1'b0;
                end else begin
                  fresh_next_nxt = fresh_next_r + CW'(1);
                end
                tbl_we                 = 1'b1;
                hvalid_nxt[alloc_slot] = 1'b1;
                out_fd_nxt             = fha_pkg::FD_W'(alloc_slot) + FIRST_FD_V;
              end else begin
                out_status_nxt = fha_pkg::ST_NO_FD;
              end
            end
            fha_pkg::CMD_FREE: begin
              if (in_range_r) begin
                // clearing the valid bit makes the entry read as zero
                hvalid_nxt[slot_r] = 1'b0;
                if (!on_free_r[slot_r] && (free_count_r < MAX_CNT)) begin
                  stk_we              = 1'b1;
                  free_count_nxt      = free_count_r + CW'(1);
                  on_free_nxt[slot_r] = 1'b1;
                end
              end else begin
                out_status_nxt = fha_pkg::ST_BAD_FD;
              end
            end
            fha_pkg::CMD_LOOKUP: begin
              if (fd_r <= fha_pkg::CONSOLE_LAST) begin
                out_console_nxt = 1'b1;
              end else if (in_range_r) begin
                out_handle_nxt = hvalid_r[slot_r] ? tbl_rdata : '0;
              end else begin
                out_status_nxt = fha_pkg::ST_BAD_FD;
              end
            end
            default: begin
              // unused selector: all-zero result
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      free_count_r  <= '0;
      fresh_next_r  <= '0;
      on_free_r     <= '0;
      hvalid_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      free_count_r  <= free_count_nxt;
      fresh_next_r  <= fresh_next_nxt;
      on_free_r     <= on_free_nxt;
      hvalid_r      <= hvalid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    fd_r          <= fd_nxt;
    handle_r      <= handle_nxt;
    slot_r        <= slot_nxt;
    in_range_r    <= in_range_nxt;
    out_status_r  <= out_status_nxt;
    out_fd_r      <= out_fd_nxt;
    out_handle_r  <= out_handle_nxt;
    out_console_r <= out_console_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_fd_out     = out_fd_r;
  assign out_handle_out = out_handle_r;
  assign out_is_console = out_console_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_matches_marks: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(on_free_r) == int'(free_count_r))
    else $error("free_count out of step with on-list marks");

  a_fresh_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_next_r <= MAX_CNT)
    else $error("fresh counter past range");

  a_pop_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && (cmd_r == fha_pkg::CMD_ALLOC) && pop_ok) |-> on_free_r[stk_rdata])
    else $error("popped slot was not marked free");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC) && !out_valid_r || (state_r == S_EXEC))
    else $error("accepted item did not enter execute");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r && (state_r == S_IDLE))
    else $error("execute did not produce a result");

endmodule

/* verif/file_handle_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_handle_allocator_tb
// Self-checking bench for the descriptor allocator. Requests go in over the
// valid/stall channel with random gaps, and results are drained with random
// stalls. A ledger class mirrors the handle table, the LIFO free stack and
// the fresh counter. It predicts one reply per accepted request and checks
// each reply, field by field and in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module file_handle_allocator_tb;

  localparam int NFILES      = fha_pkg::MAX_FILES_DEF;
  localparam int BASE_FD     = fha_pkg::FIRST_FD_DEF;
  localparam int LAST_FD     = BASE_FD + NFILES - 1;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_WAIT  = 8;

  // one reply of the block, as the bench expects it
  typedef struct {
    fha_pkg::status_t         status;
    logic [fha_pkg::FD_W-1:0] fd;
    logic [31:0]              handle;
    logic                     console;
  } reply_t;

  // --------------------------------------------------------------------------
  // Ledger: shadow copy of the allocator state plus the queue of replies that
  // are still owed by the block.
  // --------------------------------------------------------------------------
  class descriptor_ledger;
    logic [31:0] bound_handle [NFILES];
    int          free_stack   [NFILES];
    bit          on_stack     [NFILES];
    int          free_count;
    int          fresh_next;
    reply_t      awaited [$];
    int          errors;
    int          n_requests, n_alloc_ok, n_reused, n_refused, n_bad_fd, n_console;

    function new();
      for (int i = 0; i < NFILES; i++) begin
        bound_handle[i] = '0;
        free_stack[i]   = 0;
        on_stack[i]     = 1'b0;
      end
      free_count = 0;
      fresh_next = 0;
      errors     = 0;
      n_requests = 0;
      n_alloc_ok = 0;
      n_reused   = 0;
      n_refused  = 0;
      n_bad_fd   = 0;
      n_console  = 0;
    endfunction

    // Predict the reply for an accepted request and update the shadow state.
    function void note_request(fha_pkg::cmd_t cmd, logic [fha_pkg::FD_W-1:0] fd,
                               logic [31:0] h);
      reply_t r;
      int     slot;
      bit     in_range;
      r        = '{fha_pkg::ST_OK, '0, '0, 1'b0};
      slot     = int'(fd) - BASE_FD;
      in_range = (int'(fd) >= BASE_FD) && (slot < NFILES);
      n_requests++;
      case (cmd)
        fha_pkg::CMD_ALLOC: begin
          if (free_count > 0) begin
            // most recently freed number comes back first
            free_count--;
            slot           = free_stack[free_count];
            on_stack[slot] = 1'b0;
            n_reused++;
          end else if (fresh_next < NFILES) begin
            slot = fresh_next;
            fresh_next++;
          end else begin
            slot = -1;
          end
          if (slot >= 0) begin
            bound_handle[slot] = h;
            r.fd = fha_pkg::FD_W'(slot + BASE_FD);
            n_alloc_ok++;
          end else begin
            r.status = fha_pkg::ST_NO_FD;
            n_refused++;
          end
        end
        fha_pkg::CMD_FREE: begin
          if (in_range) begin
            bound_handle[slot] = '0;
            // a number already waiting on the stack is not pushed twice
            if (!on_stack[slot] && free_count < NFILES) begin
              free_stack[free_count] = slot;
              free_count++;
              on_stack[slot] = 1'b1;
            end
          end else begin
            r.status = fha_pkg::ST_BAD_FD;
            n_bad_fd++;
          end
        end
        fha_pkg::CMD_LOOKUP: begin
          if (fd <= fha_pkg::CONSOLE_LAST) begin
            r.console = 1'b1;
            n_console++;
          end else if (in_range) begin
            r.handle = bound_handle[slot];
          end else begin
            r.status = fha_pkg::ST_BAD_FD;
            n_bad_fd++;
          end
        end
        default: ;  // unused selector: all-zero reply
      endcase
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp, act);
      end
    endfunction

    function void check_result(logic [fha_pkg::STATUS_W-1:0] status,
                               logic [fha_pkg::FD_W-1:0] fd,
                               logic [31:0] handle, logic console);
      reply_t r;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply, expected none, got status %0d fd %0d",
                 $time, status, fd);
        return;
      end
      r = awaited.pop_front();
      compare_field("status", 32'(r.status), 32'(status));
      compare_field("fd_out", 32'(r.fd), 32'(fd));
      compare_field("handle_out", r.handle, handle);
      compare_field("is_console", 32'(r.console), 32'(console));
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its ports
  // --------------------------------------------------------------------------
  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [fha_pkg::CMD_W-1:0]     in_cmd;
  logic [fha_pkg::FD_W-1:0]      in_fd_number;
  logic [fha_pkg::HANDLE_W-1:0]  in_handle_in;
  logic                          out_valid;
  logic                          out_stall;
  logic [fha_pkg::STATUS_W-1:0]  out_status;
  logic [fha_pkg::FD_W-1:0]      out_fd_out;
  logic [fha_pkg::HANDLE_W-1:0]  out_handle_out;
  logic                          out_is_console;

  file_handle_allocator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_fd_number   (in_fd_number),
    .in_handle_in   (in_handle_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_fd_out     (out_fd_out),
    .out_handle_out (out_handle_out),
    .out_is_console (out_is_console)
  );

  descriptor_ledger ledger;
  int idle_pct;    // chance per cycle that the sender holds back
  int stall_pct;   // chance per cycle that the receiver stalls
  int cycle_count;

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: outputs are read as they stood at the edge, so a reply counts
  // when out_valid was high and our stall was low going into this edge. The
  // next stall value is chosen at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        ledger.check_result(out_status, out_fd_out, out_handle_out, out_is_console);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Sender: holds valid and payload until accepted. Valid is only lowered by
  // the idle loop of the next request or after the last one, so each edge
  // sees at most one update of in_valid.
  task automatic send_request(fha_pkg::cmd_t cmd, logic [fha_pkg::FD_W-1:0] fd,
                              logic [31:0] h);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_fd_number <= fd;
    in_handle_in <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_request(cmd, fd, h);
  endtask

  // Mostly numbers inside the descriptor range, some console numbers, and
  // the full 8-bit range for the rest.
  function automatic logic [fha_pkg::FD_W-1:0] pick_fd();
    int r;
    r = $urandom_range(99);
    if (r < 70) return fha_pkg::FD_W'($urandom_range(LAST_FD, BASE_FD));
    if (r < 80) return fha_pkg::FD_W'($urandom_range(2, 0));
    return fha_pkg::FD_W'($urandom_range(255, 0));
  endfunction

  function automatic logic [31:0] pick_handle();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // One random phase; alloc_pct steers how quickly the range fills up.
  task automatic run_phase(int n, int gap_pct, int hold_pct, int alloc_pct);
    int            r;
    int            free_edge;
    fha_pkg::cmd_t cmd;
    idle_pct  = gap_pct;
    stall_pct = hold_pct;
    free_edge = alloc_pct + (95 - alloc_pct) / 2;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < alloc_pct)      cmd = fha_pkg::CMD_ALLOC;
      else if (r < free_edge) cmd = fha_pkg::CMD_FREE;
      else if (r < 95)        cmd = fha_pkg::CMD_LOOKUP;
      else                    cmd = fha_pkg::CMD_NONE;
      send_request(cmd, pick_fd(), pick_handle());
    end
  endtask

  initial begin
    ledger       = new();
    idle_pct     = 0;
    stall_pct    = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_cmd       <= fha_pkg::CMD_NONE;
    in_fd_number <= '0;
    in_handle_in <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: console numbers, range edges, empty entries, out of
    // range frees, a free of a number never handed out, a repeated free and
    // the LIFO order of reuse.
    send_request(fha_pkg::CMD_LOOKUP, 8'd0, 32'h0);
    send_request(fha_pkg::CMD_LOOKUP, 8'd1, 32'h0);
    send_request(fha_pkg::CMD_LOOKUP, 8'd2, 32'h0);
    send_request(fha_pkg::CMD_LOOKUP, 8'd255, 32'hFFFF_FFFF);
    send_request(fha_pkg::CMD_LOOKUP, fha_pkg::FD_W'(BASE_FD), 32'h0);     // empty after reset
    send_request(fha_pkg::CMD_LOOKUP, fha_pkg::FD_W'(LAST_FD + 1), 32'h0); // just past the range
    send_request(fha_pkg::CMD_NONE, 8'hFF, 32'hFFFF_FFFF);
    send_request(fha_pkg::CMD_FREE, 8'd0, 32'h0);
    send_request(fha_pkg::CMD_FREE, 8'd2, 32'h0);
    send_request(fha_pkg::CMD_FREE, fha_pkg::FD_W'(LAST_FD + 1), 32'h0);
    send_request(fha_pkg::CMD_FREE, 8'd255, 32'h0);
    send_request(fha_pkg::CMD_FREE, fha_pkg::FD_W'(LAST_FD), 32'h0);       // never handed out
    send_request(fha_pkg::CMD_FREE, fha_pkg::FD_W'(LAST_FD), 32'h0);       // already on stack
    send_request(fha_pkg::CMD_ALLOC, 8'd0, 32'hFFFF_FFFF);                 // reuses LAST_FD
    send_request(fha_pkg::CMD_ALLOC, 8'hFF, 32'h0);                        // first fresh number
    send_request(fha_pkg::CMD_LOOKUP, fha_pkg::FD_W'(LAST_FD), 32'h0);
    send_request(fha_pkg::CMD_LOOKUP, fha_pkg::FD_W'(BASE_FD), 32'h0);
    send_request(fha_pkg::CMD_FREE, fha_pkg::FD_W'(BASE_FD), 32'h0);
    send_request(fha_pkg::CMD_ALLOC, 8'd0, 32'hA5A5_A5A5);
    send_request(fha_pkg::CMD_FREE, fha_pkg::FD_W'(BASE_FD), 32'h0);
    send_request(fha_pkg::CMD_FREE, fha_pkg::FD_W'(LAST_FD), 32'h0);
    send_request(fha_pkg::CMD_ALLOC, 8'd0, 32'h0000_0001);                 // LAST_FD, pushed last
    send_request(fha_pkg::CMD_ALLOC, 8'd0, 32'h8000_0000);                 // then BASE_FD
    send_request(fha_pkg::CMD_LOOKUP, fha_pkg::FD_W'(BASE_FD), 32'h0);

    // Random part over the four idle/stall mixes. The alloc-heavy phase runs
    // the fresh counter into saturation; the free-heavy one returns numbers to the free stack.
    run_phase(500, 0, 0, 40);
    run_phase(500, 46, 0, 25);
    run_phase(500, 0, 46, 55);
    run_phase(500, 32, 32, 35);

    in_valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    // anything that shows up now is an extra reply
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d requests: %0d allocations (%0d from the free stack, %0d refused)",
             ledger.n_requests, ledger.n_alloc_ok, ledger.n_reused, ledger.n_refused);
    $display("  plus %0d out-of-range requests and %0d console look-ups",
             ledger.n_bad_fd, ledger.n_console);
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* file_handle_allocator.f */
hw/rtl/fha_pkg.sv
hw/rtl/fha_ram.sv
hw/rtl/file_handle_allocator.sv
verif/file_handle_allocator_tb.sv
